FILE: rtl/cci_pkg.sv
// ---------------------------------------------------------------------------
// cci_pkg
// Shared constants and helpers for the circle-circle intersection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

    // default coordinate width, signed fixed point
    localparam int COORD_WIDTH_DEF = 32;

    // round a bit count up to whole bytes
    function automatic int byte_pad(input int bits);
        return ((bits + 7) >> 3) << 3;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cci_sqrt_cell.sv
// ---------------------------------------------------------------------------
// cci_sqrt_cell
// One digit stage of a pipelined integer square root: produces one root bit.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_sqrt_cell #(
    parameter int RAD_WIDTH  = 66,
    parameter int SIDE_WIDTH = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [RAD_WIDTH-1:0]        in_rad,
    input  wire logic [RAD_WIDTH/2-1:0]      in_root,
    input  wire logic [RAD_WIDTH/2+1:0]      in_rem,
    input  wire logic [SIDE_WIDTH-1:0]       in_side,
    output logic                             out_valid,
    output logic [RAD_WIDTH-1:0]             out_rad,
    output logic [RAD_WIDTH/2-1:0]           out_root,
    output logic [RAD_WIDTH/2+1:0]           out_rem,
    output logic [SIDE_WIDTH-1:0]            out_side
);

    localparam int ROOT_WIDTH = RAD_WIDTH / 2;
    localparam int REM_WIDTH  = ROOT_WIDTH + 2;

    logic                  valid_reg;
    logic [RAD_WIDTH-1:0]  rad_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    logic [REM_WIDTH-1:0]  rem_reg;
    logic [SIDE_WIDTH-1:0] side_reg;

    logic [REM_WIDTH-1:0]  cat;
    logic [REM_WIDTH-1:0]  trial;
    logic                  take;
    logic [RAD_WIDTH-1:0]  rad_next;
    logic [ROOT_WIDTH-1:0] root_next;
    logic [REM_WIDTH-1:0]  rem_next;

    // bring down two radicand bits and try root*4+1
    always_comb
    begin
        cat       = {in_rem[REM_WIDTH-3:0], in_rad[RAD_WIDTH-1 -: 2]};
        trial     = {in_root, 2'b01};
        take      = (cat >= trial);
        rem_next  = take ? (cat - trial) : cat;
        root_next = {in_root[ROOT_WIDTH-2:0], take};
        rad_next  = {in_rad[RAD_WIDTH-3:0], 2'b00};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: rtl/cci_div_cell.sv
// ---------------------------------------------------------------------------
// cci_div_cell
// One stage of a pipelined restoring divider: produces one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_div_cell #(
    parameter int NUM_WIDTH  = 66,
    parameter int DIV_WIDTH  = 34,
    parameter int SIDE_WIDTH = 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [NUM_WIDTH-1:0]   in_nq,
    input  wire logic [DIV_WIDTH-1:0]   in_rem,
    input  wire logic [DIV_WIDTH-1:0]   in_div,
    input  wire logic [SIDE_WIDTH-1:0]  in_side,
    output logic                        out_valid,
    output logic [NUM_WIDTH-1:0]        out_nq,
    output logic [DIV_WIDTH-1:0]        out_rem,
    output logic [DIV_WIDTH-1:0]        out_div,
    output logic [SIDE_WIDTH-1:0]       out_side
);

    logic                  valid_reg;
    logic [NUM_WIDTH-1:0]  nq_reg;
    logic [DIV_WIDTH-1:0]  rem_reg;
    logic [DIV_WIDTH-1:0]  div_reg;
    logic [SIDE_WIDTH-1:0] side_reg;

    logic [DIV_WIDTH:0]    cat;
    logic [DIV_WIDTH:0]    diff;
    logic                  take;
    logic [NUM_WIDTH-1:0]  nq_next;
    logic [DIV_WIDTH-1:0]  rem_next;

    // numerator shifts out at the top, quotient bits shift in at the bottom
    always_comb
    begin
        cat      = {in_rem, in_nq[NUM_WIDTH-1]};
        diff     = cat - {1'b0, in_div};
        take     = (cat >= {1'b0, in_div});
        rem_next = take ? diff[DIV_WIDTH-1:0] : cat[DIV_WIDTH-1:0];
        nq_next  = {in_nq[NUM_WIDTH-2:0], take};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg   <= nq_next;
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_nq    = nq_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: rtl/cci_sqrt.sv
// ---------------------------------------------------------------------------
// cci_sqrt
// Floor square root as a chain of digit cells, one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_sqrt #(
    parameter int RAD_WIDTH  = 66,
    parameter int SIDE_WIDTH = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [RAD_WIDTH-1:0]       in_rad,
    input  wire logic [SIDE_WIDTH-1:0]      in_side,
    output logic                            out_valid,
    output logic [RAD_WIDTH/2-1:0]          out_root,
    output logic [SIDE_WIDTH-1:0]           out_side
);

    localparam int ROOT_WIDTH = RAD_WIDTH / 2;
    localparam int REM_WIDTH  = ROOT_WIDTH + 2;

    logic                  valid_c [ROOT_WIDTH+1];
    logic [RAD_WIDTH-1:0]  rad_c   [ROOT_WIDTH+1];
    logic [ROOT_WIDTH-1:0] root_c  [ROOT_WIDTH+1];
    logic [REM_WIDTH-1:0]  rem_c   [ROOT_WIDTH+1];
    logic [SIDE_WIDTH-1:0] side_c  [ROOT_WIDTH+1];

    // chain head
    assign valid_c[0] = in_valid;
    assign rad_c[0]   = in_rad;
    assign root_c[0]  = '0;
    assign rem_c[0]   = '0;
    assign side_c[0]  = in_side;

    // one cell per root bit
    for (genvar i = 0; i < ROOT_WIDTH; i++)
    begin : g_cell
        cci_sqrt_cell #(
            .RAD_WIDTH  (RAD_WIDTH),
            .SIDE_WIDTH (SIDE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_c[i]),
            .in_rad    (rad_c[i]),
            .in_root   (root_c[i]),
            .in_rem    (rem_c[i]),
            .in_side   (side_c[i]),
            .out_valid (valid_c[i+1]),
            .out_rad   (rad_c[i+1]),
            .out_root  (root_c[i+1]),
            .out_rem   (rem_c[i+1]),
            .out_side  (side_c[i+1])
        );
    end

    assign out_valid = valid_c[ROOT_WIDTH];
    assign out_root  = root_c[ROOT_WIDTH];
    assign out_side  = side_c[ROOT_WIDTH];

endmodule

`default_nettype wire

FILE: rtl/cci_div.sv
// ---------------------------------------------------------------------------
// cci_div
// Unsigned divider as a chain of restoring cells, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_div #(
    parameter int NUM_WIDTH  = 66,
    parameter int DIV_WIDTH  = 34,
    parameter int SIDE_WIDTH = 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [NUM_WIDTH-1:0]   in_num,
    input  wire logic [DIV_WIDTH-1:0]   in_div,
    input  wire logic [SIDE_WIDTH-1:0]  in_side,
    output logic                        out_valid,
    output logic [NUM_WIDTH-1:0]        out_quot,
    output logic [DIV_WIDTH-1:0]        out_rem,
    output logic [DIV_WIDTH-1:0]        out_div,
    output logic [SIDE_WIDTH-1:0]       out_side
);

    logic                  valid_c [NUM_WIDTH+1];
    logic [NUM_WIDTH-1:0]  nq_c    [NUM_WIDTH+1];
    logic [DIV_WIDTH-1:0]  rem_c   [NUM_WIDTH+1];
    logic [DIV_WIDTH-1:0]  div_c   [NUM_WIDTH+1];
    logic [SIDE_WIDTH-1:0] side_c  [NUM_WIDTH+1];

    // chain head
    assign valid_c[0] = in_valid;
    assign nq_c[0]    = in_num;
    assign rem_c[0]   = '0;
    assign div_c[0]   = in_div;
    assign side_c[0]  = in_side;

    // one cell per quotient bit
    for (genvar i = 0; i < NUM_WIDTH; i++)
    begin : g_cell
        cci_div_cell #(
            .NUM_WIDTH  (NUM_WIDTH),
            .DIV_WIDTH  (DIV_WIDTH),
            .SIDE_WIDTH (SIDE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_c[i]),
            .in_nq     (nq_c[i]),
            .in_rem    (rem_c[i]),
            .in_div    (div_c[i]),
            .in_side   (side_c[i]),
            .out_valid (valid_c[i+1]),
            .out_nq    (nq_c[i+1]),
            .out_rem   (rem_c[i+1]),
            .out_div   (div_c[i+1]),
            .out_side  (side_c[i+1])
        );
    end

    assign out_valid = valid_c[NUM_WIDTH];
    assign out_quot  = nq_c[NUM_WIDTH];
    assign out_rem   = rem_c[NUM_WIDTH];
    assign out_div   = div_c[NUM_WIDTH];
    assign out_side  = side_c[NUM_WIDTH];

endmodule

`default_nettype wire

FILE: rtl/circle_circle_intersection.sv
// ---------------------------------------------------------------------------
// circle_circle_intersection
// Throughput: one request per cycle; the whole pipeline stalls only while
// the output register holds a result that is not taken.
// Latency is set by the bit-per-stage square root and divider cell chains.
// Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_circle_intersection #(
    parameter int COORD_WIDTH = cci_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    // request: first_center_x, first_center_y, first_radius,
    //          second_center_x, second_center_y, second_radius
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    input  wire logic [cci_pkg::byte_pad(6*COORD_WIDTH-2)-1:0] s_tdata,
    // result: point_a_x, point_a_y, point_b_x, point_b_y
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    output logic [cci_pkg::byte_pad(4*COORD_WIDTH)-1:0]        m_tdata,
    // result flag: found
    output logic                                               m_tuser
);

    import cci_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int IN_W  = byte_pad(6*W-2);
    localparam int OUT_W = byte_pad(4*W);
    localparam int SQ_W  = 2*W + 2;
    localparam int RR_W  = 2*W - 2;
    localparam int PR_W  = 2*W;
    localparam int SM_W  = 2*W + 2;
    localparam int MG_W  = 2*W + 1;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic            found;
        logic            neg;
        logic [SQ_W-1:0] num;
        logic [W-2:0]    r1;
        logic [RR_W-1:0] rr1;
        logic [W:0]      adx;
        logic [W:0]      ady;
        logic            sx;
        logic            sy;
        logic [W-1:0]    x1;
        logic [W-1:0]    y1;
    } dist_side_t;

    typedef struct packed {
        logic            found;
        logic            neg;
        logic [W-2:0]    r1;
        logic [RR_W-1:0] rr1;
        logic [W:0]      adx;
        logic [W:0]      ady;
        logic            sx;
        logic            sy;
        logic [W-1:0]    x1;
        logic [W-1:0]    y1;
        logic [W:0]      d;
    } offs_side_t;

    typedef struct packed {
        logic         found;
        logic         neg;
        logic [W-2:0] am;
        logic [W:0]   adx;
        logic [W:0]   ady;
        logic         sx;
        logic         sy;
        logic [W-1:0] x1;
        logic [W-1:0] y1;
        logic [W:0]   d;
    } chord_side_t;

    typedef struct packed {
        logic         neg;
        logic [W-1:0] base;
    } lane_side_t;

    typedef struct packed {
        logic       found;
        lane_side_t lane;
    } lead_side_t;

    // base plus or minus the rounded quotient, saturated to the coordinate range
    function automatic logic [W-1:0] place(input logic neg, input logic [W-1:0] base,
                                           input logic [SM_W-1:0] q);
        logic [W+2:0] bext;
        logic [W+2:0] qext;
        logic [W+2:0] sum;
        logic         ovf;
        logic         pos_ovf;
        logic         neg_ovf;
        bext    = {{3{base[W-1]}}, base};
        qext    = {2'b00, q[W:0]};
        sum     = neg ? (bext - qext) : (bext + qext);
        ovf     = |q[SM_W-1:W+1];
        pos_ovf = !sum[W+2] && (|sum[W+1:W-1]);
        neg_ovf = sum[W+2] && !(&sum[W+1:W-1]);
        if (ovf)
            return neg ? MINV : MAXV;
        else if (pos_ovf)
            return MAXV;
        else if (neg_ovf)
            return MINV;
        else
            return sum[W-1:0];
    endfunction

    // global advance: the pipeline moves unless the output holds a result that is not taken
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // request fields
    logic [W-1:0] in_x1;
    logic [W-1:0] in_y1;
    logic [W-2:0] in_r1;
    logic [W-1:0] in_x2;
    logic [W-1:0] in_y2;
    logic [W-2:0] in_r2;

    assign in_x1 = s_tdata[W-1:0];
    assign in_y1 = s_tdata[2*W-1:W];
    assign in_r1 = s_tdata[3*W-2:2*W];
    assign in_x2 = s_tdata[4*W-2:3*W-1];
    assign in_y2 = s_tdata[5*W-2:4*W-1];
    assign in_r2 = s_tdata[6*W-3:5*W-1];

    // ---------------- stage a: differences ----------------
    logic [W:0]   dx_next;
    logic [W:0]   dy_next;
    logic [W:0]   a_adx_next;
    logic [W:0]   a_ady_next;
    logic [W-1:0] a_rsum_next;
    logic [W-2:0] a_rdif_next;

    always_comb
    begin
        dx_next     = {in_x2[W-1], in_x2} - {in_x1[W-1], in_x1};
        dy_next     = {in_y2[W-1], in_y2} - {in_y1[W-1], in_y1};
        a_adx_next  = dx_next[W] ? (~dx_next + 1'b1) : dx_next;
        a_ady_next  = dy_next[W] ? (~dy_next + 1'b1) : dy_next;
        a_rsum_next = {1'b0, in_r1} + {1'b0, in_r2};
        a_rdif_next = (in_r1 > in_r2) ? (in_r1 - in_r2) : (in_r2 - in_r1);
    end

    logic         a_valid_reg;
    logic [W-1:0] a_x1_reg;
    logic [W-1:0] a_y1_reg;
    logic [W-2:0] a_r1_reg;
    logic [W-2:0] a_r2_reg;
    logic [W:0]   a_adx_reg;
    logic [W:0]   a_ady_reg;
    logic         a_sx_reg;
    logic         a_sy_reg;
    logic [W-1:0] a_rsum_reg;
    logic [W-2:0] a_rdif_reg;

    // ---------------- stage b: squares ----------------
    logic            b_valid_reg;
    logic [SQ_W-1:0] b_adx2_reg;
    logic [SQ_W-1:0] b_ady2_reg;
    logic [RR_W-1:0] b_rr1_reg;
    logic [RR_W-1:0] b_rr2_reg;
    logic [PR_W-1:0] b_rs2_reg;
    logic [RR_W-1:0] b_rd2_reg;
    logic [W-1:0]    b_x1_reg;
    logic [W-1:0]    b_y1_reg;
    logic [W-2:0]    b_r1_reg;
    logic [W:0]      b_adx_reg;
    logic [W:0]      b_ady_reg;
    logic            b_sx_reg;
    logic            b_sy_reg;

    logic [SQ_W-1:0] b_adx2_next;
    logic [SQ_W-1:0] b_ady2_next;
    logic [RR_W-1:0] b_rr1_next;
    logic [RR_W-1:0] b_rr2_next;
    logic [PR_W-1:0] b_rs2_next;
    logic [RR_W-1:0] b_rd2_next;

    assign b_adx2_next = a_adx_reg * a_adx_reg;
    assign b_ady2_next = a_ady_reg * a_ady_reg;
    assign b_rr1_next  = a_r1_reg * a_r1_reg;
    assign b_rr2_next  = a_r2_reg * a_r2_reg;
    assign b_rs2_next  = a_rsum_reg * a_rsum_reg;
    assign b_rd2_next  = a_rdif_reg * a_rdif_reg;

    // ---------------- stage c: squared distance ----------------
    logic            c_valid_reg;
    logic [SQ_W-1:0] c_d2_reg;
    logic [RR_W-1:0] c_rr1_reg;
    logic [RR_W-1:0] c_rr2_reg;
    logic [PR_W-1:0] c_rs2_reg;
    logic [RR_W-1:0] c_rd2_reg;
    logic [W-1:0]    c_x1_reg;
    logic [W-1:0]    c_y1_reg;
    logic [W-2:0]    c_r1_reg;
    logic [W:0]      c_adx_reg;
    logic [W:0]      c_ady_reg;
    logic            c_sx_reg;
    logic            c_sy_reg;

    logic [SQ_W-1:0] c_d2_next;

    assign c_d2_next = b_adx2_reg + b_ady2_reg;

    // ---------------- stage d: intersection test ----------------
    logic            d_valid_reg;
    logic            d_found_reg;
    logic [SQ_W-1:0] d_t_reg;
    logic [SQ_W-1:0] d_d2_reg;
    logic [RR_W-1:0] d_rr1_reg;
    logic [RR_W-1:0] d_rr2_reg;
    logic [W-1:0]    d_x1_reg;
    logic [W-1:0]    d_y1_reg;
    logic [W-2:0]    d_r1_reg;
    logic [W:0]      d_adx_reg;
    logic [W:0]      d_ady_reg;
    logic            d_sx_reg;
    logic            d_sy_reg;

    logic            d_found_next;
    logic [SQ_W-1:0] d_t_next;

    assign d_found_next = (c_d2_reg != '0) && (c_d2_reg <= SQ_W'(c_rs2_reg))
                          && (c_d2_reg >= SQ_W'(c_rd2_reg));
    assign d_t_next     = SQ_W'(c_rr1_reg) + c_d2_reg;

    // ---------------- stage e: offset numerator ----------------
    logic            e_valid_reg;
    logic [SQ_W-1:0] e_d2_reg;
    dist_side_t      e_side_reg;
    dist_side_t      e_side_next;

    always_comb
    begin
        e_side_next.found = d_found_reg;
        e_side_next.neg   = (d_t_reg < SQ_W'(d_rr2_reg));
        e_side_next.num   = e_side_next.neg ? (SQ_W'(d_rr2_reg) - d_t_reg)
                                            : (d_t_reg - SQ_W'(d_rr2_reg));
        e_side_next.r1    = d_r1_reg;
        e_side_next.rr1   = d_rr1_reg;
        e_side_next.adx   = d_adx_reg;
        e_side_next.ady   = d_ady_reg;
        e_side_next.sx    = d_sx_reg;
        e_side_next.sy    = d_sy_reg;
        e_side_next.x1    = d_x1_reg;
        e_side_next.y1    = d_y1_reg;
    end

    // front stages, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // front stages, payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x1_reg   <= in_x1;
            a_y1_reg   <= in_y1;
            a_r1_reg   <= in_r1;
            a_r2_reg   <= in_r2;
            a_adx_reg  <= a_adx_next;
            a_ady_reg  <= a_ady_next;
            a_sx_reg   <= dx_next[W];
            a_sy_reg   <= dy_next[W];
            a_rsum_reg <= a_rsum_next;
            a_rdif_reg <= a_rdif_next;

            b_adx2_reg <= b_adx2_next;
            b_ady2_reg <= b_ady2_next;
            b_rr1_reg  <= b_rr1_next;
            b_rr2_reg  <= b_rr2_next;
            b_rs2_reg  <= b_rs2_next;
            b_rd2_reg  <= b_rd2_next;
            b_x1_reg   <= a_x1_reg;
            b_y1_reg   <= a_y1_reg;
            b_r1_reg   <= a_r1_reg;
            b_adx_reg  <= a_adx_reg;
            b_ady_reg  <= a_ady_reg;
            b_sx_reg   <= a_sx_reg;
            b_sy_reg   <= a_sy_reg;

            c_d2_reg   <= c_d2_next;
            c_rr1_reg  <= b_rr1_reg;
            c_rr2_reg  <= b_rr2_reg;
            c_rs2_reg  <= b_rs2_reg;
            c_rd2_reg  <= b_rd2_reg;
            c_x1_reg   <= b_x1_reg;
            c_y1_reg   <= b_y1_reg;
            c_r1_reg   <= b_r1_reg;
            c_adx_reg  <= b_adx_reg;
            c_ady_reg  <= b_ady_reg;
            c_sx_reg   <= b_sx_reg;
            c_sy_reg   <= b_sy_reg;

            d_found_reg <= d_found_next;
            d_t_reg     <= d_t_next;
            d_d2_reg    <= c_d2_reg;
            d_rr1_reg   <= c_rr1_reg;
            d_rr2_reg   <= c_rr2_reg;
            d_x1_reg    <= c_x1_reg;
            d_y1_reg    <= c_y1_reg;
            d_r1_reg    <= c_r1_reg;
            d_adx_reg   <= c_adx_reg;
            d_ady_reg   <= c_ady_reg;
            d_sx_reg    <= c_sx_reg;
            d_sy_reg    <= c_sy_reg;

            e_d2_reg    <= d_d2_reg;
            e_side_reg  <= e_side_next;
        end
    end

    // ---------------- centre distance root ----------------
    logic       s1_valid;
    logic [W:0] s1_root;
    dist_side_t s1_side;

    cci_sqrt #(
        .RAD_WIDTH  (SQ_W),
        .SIDE_WIDTH ($bits(dist_side_t))
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_rad    (e_d2_reg),
        .in_side   (e_side_reg),
        .out_valid (s1_valid),
        .out_root  (s1_root),
        .out_side  (s1_side)
    );

    // ---------------- chord offset division by 2d ----------------
    offs_side_t      q1_in_side;
    logic            q1_valid;
    logic [SQ_W-1:0] q1_quot;
    logic [W+1:0]    q1_rem;
    logic [W+1:0]    q1_div;
    offs_side_t      q1_side;

    always_comb
    begin
        q1_in_side.found = s1_side.found;
        q1_in_side.neg   = s1_side.neg;
        q1_in_side.r1    = s1_side.r1;
        q1_in_side.rr1   = s1_side.rr1;
        q1_in_side.adx   = s1_side.adx;
        q1_in_side.ady   = s1_side.ady;
        q1_in_side.sx    = s1_side.sx;
        q1_in_side.sy    = s1_side.sy;
        q1_in_side.x1    = s1_side.x1;
        q1_in_side.y1    = s1_side.y1;
        q1_in_side.d     = s1_root;
    end

    cci_div #(
        .NUM_WIDTH  (SQ_W),
        .DIV_WIDTH  (W+2),
        .SIDE_WIDTH ($bits(offs_side_t))
    ) u_offs_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .in_num    (s1_side.num),
        .in_div    ({s1_root, 1'b0}),
        .in_side   (q1_in_side),
        .out_valid (q1_valid),
        .out_quot  (q1_quot),
        .out_rem   (q1_rem),
        .out_div   (q1_div),
        .out_side  (q1_side)
    );

    // ---------------- stages f to i: round, clamp, square, half chord squared ----------------
    logic            f_valid_reg;
    logic [SQ_W:0]   f_t_reg;
    offs_side_t      f_side_reg;
    logic [SQ_W:0]   f_t_next;

    assign f_t_next = {1'b0, q1_quot}
                      + (SQ_W+1)'({q1_rem, 1'b0} >= {1'b0, q1_div});

    logic            g_valid_reg;
    logic [W-2:0]    g_am_reg;
    offs_side_t      g_side_reg;
    logic [W-2:0]    g_am_next;

    assign g_am_next = (f_t_reg > (SQ_W+1)'(f_side_reg.r1)) ? f_side_reg.r1
                                                            : f_t_reg[W-2:0];

    logic            h_valid_reg;
    logic [RR_W-1:0] h_am2_reg;
    logic [W-2:0]    h_am_reg;
    offs_side_t      h_side_reg;
    logic [RR_W-1:0] h_am2_next;

    assign h_am2_next = g_am_reg * g_am_reg;

    logic            i_valid_reg;
    logic [RR_W-1:0] i_hh_reg;
    chord_side_t     i_side_reg;
    chord_side_t     i_side_next;

    always_comb
    begin
        i_side_next.found = h_side_reg.found;
        i_side_next.neg   = h_side_reg.neg;
        i_side_next.am    = h_am_reg;
        i_side_next.adx   = h_side_reg.adx;
        i_side_next.ady   = h_side_reg.ady;
        i_side_next.sx    = h_side_reg.sx;
        i_side_next.sy    = h_side_reg.sy;
        i_side_next.x1    = h_side_reg.x1;
        i_side_next.y1    = h_side_reg.y1;
        i_side_next.d     = h_side_reg.d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= q1_valid;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_t_reg    <= f_t_next;
            f_side_reg <= q1_side;
            g_am_reg   <= g_am_next;
            g_side_reg <= f_side_reg;
            h_am2_reg  <= h_am2_next;
            h_am_reg   <= g_am_reg;
            h_side_reg <= g_side_reg;
            i_hh_reg   <= h_side_reg.rr1 - h_am2_reg;
            i_side_reg <= i_side_next;
        end
    end

    // ---------------- half chord root ----------------
    logic         s2_valid;
    logic [W-2:0] s2_root;
    chord_side_t  s2_side;

    cci_sqrt #(
        .RAD_WIDTH  (RR_W),
        .SIDE_WIDTH ($bits(chord_side_t))
    ) u_chord_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (i_valid_reg),
        .in_rad    (i_hh_reg),
        .in_side   (i_side_reg),
        .out_valid (s2_valid),
        .out_root  (s2_root),
        .out_side  (s2_side)
    );

    // ---------------- stage j: products ----------------
    logic            j_valid_reg;
    logic [PR_W-1:0] j_pm_reg;
    logic [PR_W-1:0] j_qm_reg;
    logic [PR_W-1:0] j_rm_reg;
    logic [PR_W-1:0] j_sm_reg;
    logic            j_ps_reg;
    logic            j_qs_reg;
    logic            j_rs_reg;
    logic            j_ss_reg;
    logic            j_found_reg;
    logic [W-1:0]    j_x1_reg;
    logic [W-1:0]    j_y1_reg;
    logic [W:0]      j_d_reg;

    logic [PR_W-1:0] j_pm_next;
    logic [PR_W-1:0] j_qm_next;
    logic [PR_W-1:0] j_rm_next;
    logic [PR_W-1:0] j_sm_next;

    assign j_pm_next = s2_side.am * s2_side.adx;
    assign j_qm_next = s2_root * s2_side.ady;
    assign j_rm_next = s2_side.am * s2_side.ady;
    assign j_sm_next = s2_root * s2_side.adx;

    // ---------------- stage k: signed sums ----------------
    logic            k_valid_reg;
    logic [SM_W-1:0] k_sum_reg [4];
    logic            k_found_reg;
    logic [W-1:0]    k_x1_reg;
    logic [W-1:0]    k_y1_reg;
    logic [W:0]      k_d_reg;

    logic [SM_W-1:0] ps;
    logic [SM_W-1:0] qs;
    logic [SM_W-1:0] rs;
    logic [SM_W-1:0] ss;

    always_comb
    begin
        ps = j_ps_reg ? -SM_W'(j_pm_reg) : SM_W'(j_pm_reg);
        qs = j_qs_reg ? -SM_W'(j_qm_reg) : SM_W'(j_qm_reg);
        rs = j_rs_reg ? -SM_W'(j_rm_reg) : SM_W'(j_rm_reg);
        ss = j_ss_reg ? -SM_W'(j_sm_reg) : SM_W'(j_sm_reg);
    end

    // ---------------- stage l: sign and magnitude ----------------
    logic            l_valid_reg;
    logic [MG_W-1:0] l_mag_reg [4];
    logic            l_neg_reg [4];
    logic            l_found_reg;
    logic [W-1:0]    l_x1_reg;
    logic [W-1:0]    l_y1_reg;
    logic [W:0]      l_d_reg;

    logic [SM_W-1:0] l_abs_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            l_abs_next[k] = k_sum_reg[k][SM_W-1] ? -k_sum_reg[k] : k_sum_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            j_valid_reg <= s2_valid;
            k_valid_reg <= j_valid_reg;
            l_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_pm_reg    <= j_pm_next;
            j_qm_reg    <= j_qm_next;
            j_rm_reg    <= j_rm_next;
            j_sm_reg    <= j_sm_next;
            j_ps_reg    <= s2_side.neg ^ s2_side.sx;
            j_qs_reg    <= s2_side.sy;
            j_rs_reg    <= s2_side.neg ^ s2_side.sy;
            j_ss_reg    <= s2_side.sx;
            j_found_reg <= s2_side.found;
            j_x1_reg    <= s2_side.x1;
            j_y1_reg    <= s2_side.y1;
            j_d_reg     <= s2_side.d;

            // point a = p1 + a*e + h*perp, point b = p1 + a*e - h*perp
            k_sum_reg[0] <= ps - qs;
            k_sum_reg[1] <= rs + ss;
            k_sum_reg[2] <= ps + qs;
            k_sum_reg[3] <= rs - ss;
            k_found_reg  <= j_found_reg;
            k_x1_reg     <= j_x1_reg;
            k_y1_reg     <= j_y1_reg;
            k_d_reg      <= j_d_reg;

            for (int k = 0; k < 4; k++)
            begin
                l_mag_reg[k] <= l_abs_next[k][MG_W-1:0];
                l_neg_reg[k] <= k_sum_reg[k][SM_W-1];
            end
            l_found_reg <= k_found_reg;
            l_x1_reg    <= k_x1_reg;
            l_y1_reg    <= k_y1_reg;
            l_d_reg     <= k_d_reg;
        end
    end

    // ---------------- four coordinate dividers by d ----------------
    logic            q2_valid [4];
    logic [MG_W-1:0] q2_quot  [4];
    logic [W:0]      q2_rem   [4];
    logic [W:0]      q2_div   [4];
    lane_side_t      q2_lane  [4];
    lead_side_t      lead_in;
    lead_side_t      lead_out;

    assign lead_in.found     = l_found_reg;
    assign lead_in.lane.neg  = l_neg_reg[0];
    assign lead_in.lane.base = l_x1_reg;
    assign q2_lane[0]        = lead_out.lane;

    cci_div #(
        .NUM_WIDTH  (MG_W),
        .DIV_WIDTH  (W+1),
        .SIDE_WIDTH ($bits(lead_side_t))
    ) u_lane0_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l_valid_reg),
        .in_num    (l_mag_reg[0]),
        .in_div    (l_d_reg),
        .in_side   (lead_in),
        .out_valid (q2_valid[0]),
        .out_quot  (q2_quot[0]),
        .out_rem   (q2_rem[0]),
        .out_div   (q2_div[0]),
        .out_side  (lead_out)
    );

    for (genvar k = 1; k < 4; k++)
    begin : g_lane
        lane_side_t lane_in;

        // odd lanes are y coordinates
        assign lane_in.neg  = l_neg_reg[k];
        assign lane_in.base = (k % 2 == 1) ? l_y1_reg : l_x1_reg;

        cci_div #(
            .NUM_WIDTH  (MG_W),
            .DIV_WIDTH  (W+1),
            .SIDE_WIDTH ($bits(lane_side_t))
        ) u_lane_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (l_valid_reg),
            .in_num    (l_mag_reg[k]),
            .in_div    (l_d_reg),
            .in_side   (lane_in),
            .out_valid (q2_valid[k]),
            .out_quot  (q2_quot[k]),
            .out_rem   (q2_rem[k]),
            .out_div   (q2_div[k]),
            .out_side  (q2_lane[k])
        );
    end

    // ---------------- stage m: round to nearest ----------------
    logic            m_valid_reg;
    logic            m_found_reg;
    logic [SM_W-1:0] m_qr_reg   [4];
    lane_side_t      m_lane_reg [4];
    logic [SM_W-1:0] m_qr_next  [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m_qr_next[k] = {1'b0, q2_quot[k]}
                           + SM_W'({q2_rem[k], 1'b0} >= {1'b0, q2_div[k]});
        end
    end

    // ---------------- stage n: place, saturate, output register ----------------
    logic         out_found_reg;
    logic [W-1:0] out_pt_reg  [4];
    logic [W-1:0] out_pt_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            out_pt_next[k] = m_found_reg
                             ? place(m_lane_reg[k].neg, m_lane_reg[k].base, m_qr_reg[k])
                             : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= q2_valid[0] && q2_valid[1] && q2_valid[2] && q2_valid[3];
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_found_reg   <= lead_out.found;
            out_found_reg <= m_found_reg;
            for (int k = 0; k < 4; k++)
            begin
                m_qr_reg[k]   <= m_qr_next[k];
                m_lane_reg[k] <= q2_lane[k];
                out_pt_reg[k] <= out_pt_next[k];
            end
        end
    end

    // result ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = OUT_W'({out_pt_reg[3], out_pt_reg[2], out_pt_reg[1], out_pt_reg[0]});

    // upper request padding carries nothing
    logic unused_pad;
    assign unused_pad = ^s_tdata[IN_W-1:6*W-2];

endmodule

`default_nettype wire
